// ===== rtl/refcounted_capability_bitmap_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the refcounted capability bitmap
// Clocked on clk_i; the reset-qualified form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_CAPABILITY_BITMAP_ASSERT_SVH
`define REFCOUNTED_CAPABILITY_BITMAP_ASSERT_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define RCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rcb assertion failed");
// checked on every edge, reset included
`define RCB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rcb assertion failed");
`else
`define RCB_ASSERT(lbl, prop)
`define RCB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/rcb_pkg.sv =====
// ----------------------------------------------------------------------------
// rcb_pkg
// Shared types and constants of the refcounted capability bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package rcb_pkg;

  localparam int WORDS_DEF     = 1;
  localparam int BITS_PER_WORD = 32;
  localparam int WIDX_W        = 3;
  localparam int CNT_W         = 15;
  localparam int FLOOR_W       = 6;
  localparam int ROW_W         = BITS_PER_WORD * CNT_W;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 6'd32;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  typedef enum logic {
    OP_REGISTER   = 1'b0,
    OP_UNREGISTER = 1'b1
  } op_e;

  // one row of counters: all bits of one capability word of one set
  typedef logic [BITS_PER_WORD-1:0][CNT_W-1:0] cnt_row_t;

  typedef struct packed {
    logic [BITS_PER_WORD-1:0] old_agg;
    logic [BITS_PER_WORD-1:0] new_agg;
    logic                     hit;
  } upd_t;

endpackage

`default_nettype wire

// ===== rtl/rcb_ram.sv =====
// ----------------------------------------------------------------------------
// rcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rcb_update.sv =====
// ----------------------------------------------------------------------------
// rcb_update
// Counter update of one capability word: 32 saturating counters in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module rcb_update (
  input  wire logic                                  op_i,
  input  wire logic [rcb_pkg::BITS_PER_WORD-1:0]     cap_i,
  input  wire rcb_pkg::cnt_row_t                     row_i,
  output rcb_pkg::cnt_row_t                          row_o,
  output rcb_pkg::upd_t                              res_o
);

  always_comb begin
    logic [rcb_pkg::CNT_W-1:0] c;
    row_o         = row_i;
    res_o.old_agg = '0;
    res_o.new_agg = '0;
    res_o.hit     = 1'b0;
    for (int b = 0; b < rcb_pkg::BITS_PER_WORD; b++) begin
      c = row_i[b];
      res_o.old_agg[b] = (c != '0);
      if (cap_i[b]) begin
        if (op_i == rcb_pkg::OP_REGISTER) begin
          if (c == '0) begin
            res_o.hit = 1'b1;
          end
          if (c != rcb_pkg::CNT_MAX) begin
            c = c + 1'b1;
          end
        end else begin
          // at one or already zero: clamp and flag a change
          if (c <= rcb_pkg::CNT_W'(1)) begin
            c         = '0;
            res_o.hit = 1'b1;
          end else begin
            c = c - 1'b1;
          end
        end
      end
      row_o[b]         = c;
      res_o.new_agg[b] = (c != '0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/refcounted_capability_bitmap.sv =====
// ----------------------------------------------------------------------------
// refcounted_capability_bitmap
// Two sets of per-bit reference counters with an aggregate OR bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation, which_set, word_index and cap_word
//   with start_i high; the word is taken at that edge. busy_o is always low,
//   so one word can be issued every cycle.
//   Config: cfg_we_i writes reserved_bit_floor from cfg_wdata_i at the edge;
//   write it only while no word is in flight.
//   Result: done_o strobes for one cycle with status, merged word, flags and
//   last_of_call. The receiver cannot stall; each result is a transfer that
//   completes at the end of its strobe cycle.
//   Path: input register and counter RAM read, then update and result
//   register, which drives the ports. Throughput: one word per cycle, set
//   by the single counter-row RAM read and write port; a word hitting the
//   row written just before is served by a bypass.
//   Reset: counters read as zero through per-row valid bits, flags clear,
//   floor goes to 32 (check disabled). No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "refcounted_capability_bitmap_assert.svh"

module refcounted_capability_bitmap #(
  parameter int WORDS = rcb_pkg::WORDS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rcb_pkg::FLOOR_W-1:0]         cfg_wdata_i,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic                                operation_i,
  input  wire logic                                which_set_i,
  input  wire logic [rcb_pkg::WIDX_W-1:0]          word_index_i,
  input  wire logic [rcb_pkg::BITS_PER_WORD-1:0]   cap_word_i,
  output logic                                     done_o,
  output logic                                     status_o,
  output logic [rcb_pkg::BITS_PER_WORD-1:0]        merged_word_o,
  output logic                                     changed_o,
  output logic                                     empty_res_o,
  output logic                                     last_of_call_o
);

  localparam int ROWS   = 2 * WORDS;
  localparam int ROW_AW = $clog2(ROWS);

  localparam logic [rcb_pkg::WIDX_W:0]   WORDS_V = (rcb_pkg::WIDX_W + 1)'(WORDS);
  localparam logic [rcb_pkg::WIDX_W-1:0] LAST_W  = rcb_pkg::WIDX_W'(WORDS - 1);

  // ---- accept and counter-row read ----
  logic              accept;
  logic [ROW_AW-1:0] rd_row;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign rd_row = which_set_i ? (ROW_AW'(WORDS) + ROW_AW'(word_index_i))
                              : ROW_AW'(word_index_i);

  // ---- input register ----
  logic                                s1_valid_q;
  logic                                s1_op_q;
  logic                                s1_set_q;
  logic [rcb_pkg::WIDX_W-1:0]          s1_w_q;
  logic [rcb_pkg::BITS_PER_WORD-1:0]   s1_cap_q;
  logic [ROW_AW-1:0]                   s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= operation_i;
      s1_set_q <= which_set_i;
      s1_w_q   <= word_index_i;
      s1_cap_q <= cap_word_i;
      s1_row_q <= rd_row;
    end
  end

  // ---- config ----
  logic [rcb_pkg::FLOOR_W-1:0] floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= rcb_pkg::FLOOR_RST;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  // ---- counter RAM, valid bits and write bypass ----
  logic                  ram_we;
  logic [rcb_pkg::ROW_W-1:0] ram_rdata;
  rcb_pkg::cnt_row_t     row_cur;
  rcb_pkg::cnt_row_t     row_new;
  rcb_pkg::upd_t         upd;
  logic [ROWS-1:0]       row_valid_q;
  logic                  lw_valid_q;
  logic [ROW_AW-1:0]     lw_row_q;
  rcb_pkg::cnt_row_t     lw_data_q;

  rcb_ram #(
    .WIDTH (rcb_pkg::ROW_W),
    .DEPTH (ROWS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_row_q),
    .wdata_i (row_new),
    .re_i    (accept),
    .raddr_i (rd_row),
    .rdata_o (ram_rdata)
  );

  // the RAM read at the accept edge misses a write of the same edge
  always_comb begin
    if (lw_valid_q && (lw_row_q == s1_row_q)) begin
      row_cur = lw_data_q;
    end else if (row_valid_q[s1_row_q]) begin
      row_cur = ram_rdata;
    end else begin
      row_cur = '0;
    end
  end

  rcb_update u_update (
    .op_i  (s1_op_q),
    .cap_i (s1_cap_q),
    .row_i (row_cur),
    .row_o (row_new),
    .res_o (upd)
  );

  // ---- call control and flags ----
  logic       rej_q;
  logic [1:0] changed_q;
  logic [1:0] empty_q;
  logic       in_range;
  logic       first;
  logic       floor_hit;
  logic       rej_n;
  logic       start_ok;
  logic       upd_en;
  logic       chg_new;
  logic       emp_new;
  logic       is_unreg;

  assign is_unreg  = (s1_op_q == rcb_pkg::OP_UNREGISTER);
  assign in_range  = ({1'b0, s1_w_q} < WORDS_V);
  assign first     = (s1_w_q == '0);
  assign floor_hit = !floor_q[rcb_pkg::FLOOR_W-1] &&
                     ((s1_cap_q >> floor_q[rcb_pkg::FLOOR_W-2:0]) != '0);
  assign rej_n     = first ? floor_hit : rej_q;
  assign start_ok  = in_range && first && !floor_hit;
  assign upd_en    = in_range && !rej_n;
  assign ram_we    = s1_valid_q && upd_en;

  always_comb begin
    chg_new = start_ok ? 1'b0 : changed_q[s1_set_q];
    emp_new = (start_ok && is_unreg) ? 1'b1 : empty_q[s1_set_q];
    if (upd_en) begin
      chg_new = chg_new | upd.hit;
      if (is_unreg && (upd.new_agg != '0)) begin
        emp_new = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rej_q       <= 1'b0;
      changed_q   <= '0;
      empty_q     <= '0;
      row_valid_q <= '0;
      lw_valid_q  <= 1'b0;
    end else begin
      lw_valid_q <= ram_we;
      if (s1_valid_q) begin
        changed_q[s1_set_q] <= chg_new;
        empty_q[s1_set_q]   <= emp_new;
        if (in_range) begin
          rej_q <= rej_n;
        end
      end
      if (ram_we) begin
        row_valid_q[s1_row_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      lw_row_q  <= s1_row_q;
      lw_data_q <= row_new;
    end
  end

  // ---- result register ----
  logic                              done_q;
  logic                              status_q;
  logic [rcb_pkg::BITS_PER_WORD-1:0] merged_q;
  logic                              changed_res_q;
  logic                              empty_res_q;
  logic                              last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      status_q      <= (in_range && rej_n) ? rcb_pkg::STATUS_REJECTED
                                           : rcb_pkg::STATUS_OK;
      merged_q      <= !in_range ? '0 : (upd_en ? upd.new_agg : upd.old_agg);
      changed_res_q <= chg_new;
      empty_res_q   <= is_unreg ? emp_new : 1'b0;
      last_q        <= in_range && (s1_w_q == LAST_W);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign merged_word_o  = merged_q;
  assign changed_o      = changed_res_q;
  assign empty_res_o    = empty_res_q;
  assign last_of_call_o = last_q;

  // ---- assertions ----
  `RCB_ASSERT(a_item_latency, accept |-> ##2 done_o)
  `RCB_ASSERT(a_reg_grows, (s1_valid_q && upd_en && !is_unreg) |-> ((upd.old_agg & ~upd.new_agg) == '0))
  `RCB_ASSERT(a_unreg_shrinks, (s1_valid_q && upd_en && is_unreg) |-> ((upd.new_agg & ~upd.old_agg) == '0))
  `RCB_ASSERT(a_reject_no_write, (s1_valid_q && in_range && first && floor_hit) |-> !ram_we)
  `RCB_ASSERT_ALWAYS(a_bypass_row_valid, lw_valid_q |-> row_valid_q[lw_row_q])

endmodule

`default_nettype wire
